/* hdl/vsar_pkg.sv */
package vsar_pkg;

    // Request codes carried on the request type field.
    localparam logic [3:0] REQ_CTRL   = 4'd0;
    localparam logic [3:0] REQ_SCROLL = 4'd1;
    localparam logic [3:0] REQ_ADDR   = 4'd2;
    localparam logic [3:0] REQ_STATUS = 4'd3;
    localparam logic [3:0] REQ_DATA   = 4'd4;
    localparam logic [3:0] REQ_INCX   = 4'd5;
    localparam logic [3:0] REQ_INCY   = 4'd6;
    localparam logic [3:0] REQ_COPYH  = 4'd7;
    localparam logic [3:0] REQ_COPYV  = 4'd8;

    localparam int unsigned ADDR_W  = 15;
    localparam int unsigned FETCH_W = 14;

    // Fetch address bases: nametable area and attribute table offset within it.
    localparam logic [FETCH_W-1:0] NT_BASE   = 14'h2000;
    localparam logic [FETCH_W-1:0] ATTR_BASE = 14'h23C0;

    // Data access steps: one byte or one tile row.
    localparam logic [ADDR_W-1:0] STEP_COL = 15'd1;
    localparam logic [ADDR_W-1:0] STEP_ROW = 15'd32;

    // Coarse Y values with special wrap behavior.
    localparam logic [4:0] CY_LAST_ROW = 5'd29;
    localparam logic [4:0] CY_MAX      = 5'd31;

    typedef struct packed {
        logic [ADDR_W-1:0] cur_addr;
        logic [ADDR_W-1:0] tmp_addr;
        logic [2:0]        fine_x;
        logic              second_write;
        logic              step_by_row;
    } scroll_state_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  vram_addr;
        logic [2:0]         fine_x;
        logic               toggle;
        logic [FETCH_W-1:0] name_fetch_addr;
        logic [FETCH_W-1:0] attr_fetch_addr;
    } scroll_result_t;

endpackage

/* hdl/vsar_update.sv */
module vsar_update (
    input  logic [3:0]               req_type,
    input  logic [7:0]               data_byte,
    input  vsar_pkg::scroll_state_t  state,
    output vsar_pkg::scroll_state_t  state_next,
    output vsar_pkg::scroll_result_t result
);
    import vsar_pkg::*;

    logic [ADDR_W-1:0] shown;

    always_comb begin
        state_next = state;
        case (req_type)
            REQ_CTRL: begin
                state_next.tmp_addr[11:10] = data_byte[1:0];
                state_next.step_by_row     = data_byte[2];
            end
            REQ_SCROLL: begin
                if (!state.second_write) begin
                    state_next.fine_x        = data_byte[2:0];
                    state_next.tmp_addr[4:0] = data_byte[7:3];
                end else begin
                    state_next.tmp_addr[14:12] = data_byte[2:0];
                    state_next.tmp_addr[9:5]   = data_byte[7:3];
                end
                state_next.second_write = ~state.second_write;
            end
            REQ_ADDR: begin
                if (!state.second_write) begin
                    state_next.tmp_addr[13:8] = data_byte[5:0];
                    state_next.tmp_addr[14]   = 1'b0;
                end else begin
                    state_next.tmp_addr[7:0] = data_byte;
                    state_next.cur_addr      = {state.tmp_addr[14:8], data_byte};
                end
                state_next.second_write = ~state.second_write;
            end
            REQ_STATUS: begin
                state_next.second_write = 1'b0;
            end
            REQ_INCX: begin
                // Wrapping off the right edge moves to the horizontally adjacent nametable.
                if (state.cur_addr[4:0] == 5'h1F) begin
                    state_next.cur_addr[4:0] = 5'd0;
                    state_next.cur_addr[10]  = ~state.cur_addr[10];
                end else begin
                    state_next.cur_addr[4:0] = state.cur_addr[4:0] + 5'd1;
                end
            end
            REQ_INCY: begin
                if (state.cur_addr[14:12] != 3'd7) begin
                    state_next.cur_addr[14:12] = state.cur_addr[14:12] + 3'd1;
                end else begin
                    state_next.cur_addr[14:12] = 3'd0;
                    if (state.cur_addr[9:5] == CY_LAST_ROW) begin
                        state_next.cur_addr[9:5] = 5'd0;
                        state_next.cur_addr[11]  = ~state.cur_addr[11];
                    end else if (state.cur_addr[9:5] == CY_MAX) begin
                        state_next.cur_addr[9:5] = 5'd0;
                    end else begin
                        state_next.cur_addr[9:5] = state.cur_addr[9:5] + 5'd1;
                    end
                end
            end
            REQ_COPYH: begin
                state_next.cur_addr[4:0] = state.tmp_addr[4:0];
                state_next.cur_addr[10]  = state.tmp_addr[10];
            end
            REQ_COPYV: begin
                state_next.cur_addr[9:5]   = state.tmp_addr[9:5];
                state_next.cur_addr[14:11] = state.tmp_addr[14:11];
            end
            default: begin
                // Data accesses step below; unused codes change nothing.
            end
        endcase

        // A data access reports the address it used, then steps it.
        shown = state_next.cur_addr;
        if (req_type == REQ_DATA) begin
            state_next.cur_addr = shown + (state.step_by_row ? STEP_ROW : STEP_COL);
        end
    end

    assign result.vram_addr       = shown;
    assign result.fine_x          = state_next.fine_x;
    assign result.toggle          = state_next.second_write;
    assign result.name_fetch_addr = NT_BASE | {2'b00, shown[11:0]};
    assign result.attr_fetch_addr = ATTR_BASE
                                  | {2'b00, shown[11:10], 4'b0000, shown[9:7], shown[4:2]};

endmodule

/* hdl/video_scroll_address_registers.sv */
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_req_type, s_data_byte
// m_        out        m_valid / m_ready  m_vram_addr, m_fine_x_out, m_toggle_out,
//                                         m_name_fetch_addr, m_attr_fetch_addr
//
// Each transfer in produces exactly one transfer out, from the registered result.
// A new item may be taken every cycle; the rate is set by the single result register.
// The register file updates in the cycle the input transfer completes.
// Reset (aresetn low, synchronous) clears all addresses, fine X, the toggle and the step mode.
// When the result is not taken, s_ready drops until the held result leaves.
module video_scroll_address_registers (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [3:0]                     s_req_type,
    input  logic [7:0]                     s_data_byte,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [vsar_pkg::ADDR_W-1:0]    m_vram_addr,
    output logic [2:0]                     m_fine_x_out,
    output logic                           m_toggle_out,
    output logic [vsar_pkg::FETCH_W-1:0]   m_name_fetch_addr,
    output logic [vsar_pkg::FETCH_W-1:0]   m_attr_fetch_addr
);
    import vsar_pkg::*;

    // Architectural scroll state, and the state this item would leave behind.
    scroll_state_t  state_reg;
    scroll_state_t  state_next;

    // Result computed from the incoming item, and the result register that holds it.
    scroll_result_t result_next;
    scroll_result_t result_reg;
    logic           m_valid_reg;

    logic           in_xfer;

    // The result register can take a new item when it is empty or being emptied
    // in this same cycle, so back-to-back items flow without a bubble.
    assign s_ready = !m_valid_reg || m_ready;
    assign in_xfer = s_valid && s_ready;

    vsar_update u_update (
        .req_type   (s_req_type),
        .data_byte  (s_data_byte),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (in_xfer) begin
                state_reg <= state_next;
            end
            if (in_xfer) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload needs no reset; it is qualified by m_valid.
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            result_reg <= result_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_vram_addr       = result_reg.vram_addr;
    assign m_fine_x_out      = result_reg.fine_x;
    assign m_toggle_out      = result_reg.toggle;
    assign m_name_fetch_addr = result_reg.name_fetch_addr;
    assign m_attr_fetch_addr = result_reg.attr_fetch_addr;

endmodule

/* hdl/vsar_checker.sv */
module vsar_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [3:0]                    s_req_type,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [vsar_pkg::ADDR_W-1:0]   m_vram_addr,
    input logic                          m_toggle_out,
    input logic [vsar_pkg::FETCH_W-1:0]  m_name_fetch_addr
);
    import vsar_pkg::*;

    // A held result stays until it is taken.
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before transfer");

    // Every input transfer yields a result in the next cycle.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("input transfer without a result");

    // An empty output never stalls the input.
    a_no_false_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while output empty");

    // A status read always leaves the toggle cleared.
    a_status_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_req_type == REQ_STATUS |=> !m_toggle_out)
        else $error("toggle set after status read");

    // The nametable fetch address follows the reported address.
    a_name_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_name_fetch_addr == (NT_BASE | {2'b00, m_vram_addr[11:0]}))
        else $error("nametable fetch address mismatch");

endmodule

bind video_scroll_address_registers vsar_checker u_vsar_checker (.*);

/* tb/video_scroll_address_registers_test.sv */
module video_scroll_address_registers_test;
    import vsar_pkg::*;

    // One processor access or rendering step as it is presented on the input channel.
    typedef struct packed {
        logic [3:0] req;
        logic [7:0] data;
    } bus_access_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    // Every input of the block has a known value from time zero.
    logic s_valid = 1'b0;
    logic [3:0] s_req_type = REQ_CTRL;
    logic [7:0] s_data_byte = 8'h00;
    logic m_ready = 1'b0;

    logic s_ready;
    logic m_valid;
    logic [ADDR_W-1:0] m_vram_addr;
    logic [2:0] m_fine_x_out;
    logic m_toggle_out;
    logic [FETCH_W-1:0] m_name_fetch_addr;
    logic [FETCH_W-1:0] m_attr_fetch_addr;

    // Accesses waiting to be driven, and the results the scroll model predicts for
    // accesses that the block has already taken.
    bus_access_t pending_accesses[$];
    scroll_result_t predicted_results[$];

    // Private copy of the scroll registers, advanced once per input transfer.
    logic [ADDR_W-1:0] model_cur;
    logic [ADDR_W-1:0] model_tmp;
    logic [2:0] model_fine_x;
    logic model_toggle;
    logic model_row_step;

    int unsigned failures = 0;
    int unsigned accesses_sent = 0;
    int unsigned accesses_taken = 0;
    int unsigned results_checked = 0;
    int unsigned req_hits[16];
    int unsigned y_wraps = 0;
    logic in_taken = 1'b0;
    bus_access_t next_access;
    scroll_result_t got_result;
    scroll_result_t want_result;

    video_scroll_address_registers dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_data_byte       (s_data_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_vram_addr       (m_vram_addr),
        .m_fine_x_out      (m_fine_x_out),
        .m_toggle_out      (m_toggle_out),
        .m_name_fetch_addr (m_name_fetch_addr),
        .m_attr_fetch_addr (m_attr_fetch_addr)
    );

    always #5 aclk = ~aclk;

    // Applies one access to the private register copy and returns the result the
    // block must report for it. A data access reports the address it used, then
    // steps by one byte or by one tile row.
    function automatic scroll_result_t apply_access(input logic [3:0] req,
                                                    input logic [7:0] d);
        scroll_result_t r;
        logic [ADDR_W-1:0] shown;
        case (req)
            REQ_CTRL: begin
                model_tmp[11:10] = d[1:0];
                model_row_step = d[2];
            end
            REQ_SCROLL: begin
                if (!model_toggle) begin
                    model_fine_x = d[2:0];
                    model_tmp[4:0] = d[7:3];
                end else begin
                    model_tmp[14:12] = d[2:0];
                    model_tmp[9:5] = d[7:3];
                end
                model_toggle = ~model_toggle;
            end
            REQ_ADDR: begin
                if (!model_toggle) begin
                    model_tmp[13:8] = d[5:0];
                    model_tmp[14] = 1'b0;
                end else begin
                    model_tmp[7:0] = d;
                    model_cur = model_tmp;
                end
                model_toggle = ~model_toggle;
            end
            REQ_STATUS: begin
                model_toggle = 1'b0;
            end
            REQ_INCX: begin
                // Past the last tile column the fetch moves into the neighboring
                // horizontal nametable.
                if (model_cur[4:0] == 5'd31) begin
                    model_cur[4:0] = 5'd0;
                    model_cur[10] = ~model_cur[10];
                end else begin
                    model_cur[4:0] = model_cur[4:0] + 5'd1;
                end
            end
            REQ_INCY: begin
                if (model_cur[14:12] != 3'd7) begin
                    model_cur[14:12] = model_cur[14:12] + 3'd1;
                end else begin
                    model_cur[14:12] = 3'd0;
                    // The last visible tile row wraps into the vertical neighbor; row 31, in
                    // the attribute area, wraps back without switching.
                    if (model_cur[9:5] == 5'd29) begin
                        model_cur[9:5] = 5'd0;
                        model_cur[11] = ~model_cur[11];
                        y_wraps++;
                    end else if (model_cur[9:5] == 5'd31) begin
                        model_cur[9:5] = 5'd0;
                    end else begin
                        model_cur[9:5] = model_cur[9:5] + 5'd1;
                    end
                end
            end
            REQ_COPYH: begin
                model_cur[4:0] = model_tmp[4:0];
                model_cur[10] = model_tmp[10];
            end
            REQ_COPYV: begin
                model_cur[9:5] = model_tmp[9:5];
                model_cur[14:11] = model_tmp[14:11];
            end
            default: begin
            end
        endcase
        shown = model_cur;
        if (req == REQ_DATA) begin
            model_cur = model_cur + (model_row_step ? 15'd32 : 15'd1);
        end
        r.vram_addr = shown;
        r.fine_x = model_fine_x;
        r.toggle = model_toggle;
        r.name_fetch_addr = NT_BASE | {2'b00, shown[11:0]};
        r.attr_fetch_addr = ATTR_BASE | {2'b00, shown[11:10], 4'b0000, shown[9:7], shown[4:2]};
        return r;
    endfunction

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
            failures++;
        end
    endtask

    task automatic queue_access(input logic [3:0] req, input logic [7:0] d);
        bus_access_t a;
        a.req = req;
        a.data = d;
        pending_accesses = {pending_accesses, a};
    endtask

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    // Pacing runs in blocks of 250 accesses: no idling, a mostly idle sender, a
    // mostly stalling receiver, and light idling on both sides, then repeats.
    // The directed accesses fall in the first block, which has no idling.
    function automatic int unsigned pacing_mode();
        return (accesses_sent / 250) % 4;
    endfunction

    function automatic logic chance(input int unsigned pct);
        return $urandom_range(99) < pct;
    endfunction

    // Driver: inputs change only on the falling edge. A new access is offered
    // once the previous one has been transferred, or when the channel is empty,
    // so valid and the payload hold steady while the block is not ready.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || in_taken) begin
                if (pending_accesses.size() != 0 &&
                    !chance(pacing_mode() == 1 ? 68 : pacing_mode() == 3 ? 17 : 0)) begin
                    next_access = pending_accesses[0];
                    pending_accesses.delete(0);
                    s_valid <= 1'b1;
                    s_req_type <= next_access.req;
                    s_data_byte <= next_access.data;
                    accesses_sent++;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= !chance(pacing_mode() == 2 ? 68 : pacing_mode() == 3 ? 17 : 0);
        end
    end

    // Monitor: both channels are sampled on the rising edge. A result transfer
    // always belongs to an earlier access, so it is checked before the access
    // taken at the same edge is added to the predictions.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got_result.vram_addr = m_vram_addr;
                got_result.fine_x = m_fine_x_out;
                got_result.toggle = m_toggle_out;
                got_result.name_fetch_addr = m_name_fetch_addr;
                got_result.attr_fetch_addr = m_attr_fetch_addr;
                if (predicted_results.size() == 0) begin
                    $error("result transfer with no access outstanding: vram_addr 0x%0h",
                           m_vram_addr);
                    failures++;
                end else begin
                    want_result = predicted_results[0];
                    predicted_results.delete(0);
                    check_field("vram_addr", 32'(want_result.vram_addr),
                                32'(got_result.vram_addr));
                    check_field("fine_x_out", 32'(want_result.fine_x),
                                32'(got_result.fine_x));
                    check_field("toggle_out", 32'(want_result.toggle),
                                32'(got_result.toggle));
                    check_field("name_fetch_addr", 32'(want_result.name_fetch_addr),
                                32'(got_result.name_fetch_addr));
                    check_field("attr_fetch_addr", 32'(want_result.attr_fetch_addr),
                                32'(got_result.attr_fetch_addr));
                    results_checked++;
                end
            end
            in_taken = s_valid && s_ready;
            if (in_taken) begin
                predicted_results = {predicted_results,
                                     apply_access(s_req_type, s_data_byte)};
                req_hits[s_req_type]++;
                accesses_taken++;
            end
        end else begin
            in_taken = 1'b0;
        end
    end

    // Stimulus, reset and the end of the run.
    initial begin
        int unsigned kind;
        int unsigned n;
        model_cur = '0;
        model_tmp = '0;
        model_fine_x = '0;
        model_toggle = 1'b0;
        model_row_step = 1'b0;

        // Directed accesses. Fill every field of the temporary address with ones
        // and copy it across, so the current address sits at its maximum; a
        // row-step data access then wraps past the top of the address space.
        queue_access(REQ_CTRL, 8'hFF);
        queue_access(REQ_SCROLL, 8'hFF);
        queue_access(REQ_SCROLL, 8'hFF);
        queue_access(REQ_COPYH, 8'h00);
        queue_access(REQ_COPYV, 8'h00);
        queue_access(REQ_DATA, 8'h00);
        // Coarse X is 31 here, so the increment wraps into the next nametable.
        queue_access(REQ_INCX, 8'h00);
        queue_access(REQ_CTRL, 8'h00);
        queue_access(REQ_DATA, 8'hFF);
        // A status read between the two halves of an address write restarts it.
        queue_access(REQ_ADDR, 8'h3F);
        queue_access(REQ_STATUS, 8'h00);
        queue_access(REQ_ADDR, 8'hFF);
        queue_access(REQ_ADDR, 8'h00);
        queue_access(REQ_ADDR, 8'h00);
        queue_access(REQ_ADDR, 8'hFF);
        // Fine Y 7 on the last visible tile row, then fine Y 7 on row 31: the
        // first wrap switches the vertical nametable, the second does not.
        queue_access(REQ_SCROLL, 8'h00);
        queue_access(REQ_SCROLL, 8'hEF);
        queue_access(REQ_COPYV, 8'h00);
        queue_access(REQ_INCY, 8'h00);
        queue_access(REQ_SCROLL, 8'h00);
        queue_access(REQ_SCROLL, 8'hFF);
        queue_access(REQ_COPYV, 8'h00);
        queue_access(REQ_INCY, 8'h00);
        // Unused request codes must leave the registers alone.
        queue_access(4'd9, 8'hA5);
        queue_access(4'd15, 8'h5A);

        // Random part. About half of it is whole register sequences with random bytes,
        // usually preceded by a status read so the toggle starts from the first
        // write; the rest is control writes, rendering bursts and single accesses of any code.
        while (pending_accesses.size() < 2000) begin
            kind = $urandom_range(99);
            if (kind < 25) begin
                if (chance(75)) begin
                    queue_access(REQ_STATUS, rand_byte());
                end
                queue_access(REQ_SCROLL, rand_byte());
                queue_access(REQ_SCROLL, rand_byte());
            end else if (kind < 45) begin
                if (chance(75)) begin
                    queue_access(REQ_STATUS, rand_byte());
                end
                queue_access(REQ_ADDR, rand_byte());
                queue_access(REQ_ADDR, rand_byte());
                n = $urandom_range(6);
                repeat (n) queue_access(REQ_DATA, rand_byte());
            end else if (kind < 53) begin
                queue_access(REQ_CTRL, rand_byte());
            end else if (kind < 85) begin
                // A stretch of rendering: reload the vertical position, then walk
                // across and down, reloading the horizontal position now and then.
                queue_access(REQ_COPYV, rand_byte());
                n = $urandom_range(12, 1);
                repeat (n) begin
                    case ($urandom_range(3))
                        0: queue_access(REQ_INCX, rand_byte());
                        1: queue_access(REQ_INCX, rand_byte());
                        2: queue_access(REQ_INCY, rand_byte());
                        default: queue_access(REQ_COPYH, rand_byte());
                    endcase
                end
            end else begin
                queue_access(4'($urandom_range(15)), rand_byte());
            end
        end

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_accesses.size() != 0 || s_valid || predicted_results.size() != 0) begin
            @(posedge aclk);
        end
        // The block answers each transfer from its result register; a few more edges
        // expose any result it should not have produced.
        repeat (10) @(posedge aclk);

        $display("Checked %0d results for %0d accesses (%0d bus writes, %0d data accesses,",
                 results_checked, accesses_taken,
                 req_hits[REQ_CTRL] + req_hits[REQ_SCROLL] + req_hits[REQ_ADDR],
                 req_hits[REQ_DATA]);
        $display("  %0d Y increments with %0d nametable wraps) under four pacing modes.",
                 req_hits[REQ_INCY], y_wraps);
        if (failures == 0) begin
            $display("** video_scroll_address_registers: PASSED **");
        end else begin
            $display("** video_scroll_address_registers: FAILED **");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("Timeout with %0d accesses pending and %0d results outstanding.",
                 pending_accesses.size(), predicted_results.size());
        $display("** video_scroll_address_registers: FAILED **");
        $finish;
    end

endmodule
